// ===== rtl/ready_queue_min_quantum_select_assert.svh =====
// Assertion macros used by the run queue sequencer.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef READY_QUEUE_MIN_QUANTUM_SELECT_ASSERT_SVH
`define READY_QUEUE_MIN_QUANTUM_SELECT_ASSERT_SVH

// Same-cycle implication.
`define RQMS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define RQMS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/rqms_pkg.sv =====
package rqms_pkg;

	localparam int QUEUE_DEPTH  = 16;
	localparam int ID_BITS      = 8;
	localparam int QUANTUM_BITS = 16;

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		FN_PUSH   = 3'd0,
		FN_POP    = 3'd1,
		FN_REMOVE = 3'd2,
		FN_SELECT = 3'd3,
		FN_UPDATE = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_MISSING = 2'd3
	} status_t;

	// One queue entry as it is stored in the entry memory.
	typedef struct packed {
		logic [ID_BITS-1:0]      id;
		logic                    rdy;
		logic [QUANTUM_BITS-1:0] qnt;
	} entry_t;

	// Result of one operation, handed from the sequencer to the output register.
	typedef struct packed {
		logic                    front_valid;
		logic [ID_BITS-1:0]      front_id;
		logic                    front_ready;
		logic [QUANTUM_BITS-1:0] front_quantum;
		logic [CNT_W-1:0]        occupancy;
		status_t                 status;
	} result_t;

endpackage

// ===== rtl/ready_queue_min_quantum_select.sv =====
// Push, unused codes and any operation on an empty queue go from idle through the
// head read to done. Remove and update scan the entries (read, then evaluate) up
// to the match; remove and pop then move each later entry forward (read, write);
// select scans all entries and moves each entry ahead of the chosen one back.
// One operation at a time: a new transaction is accepted only in idle, after the
// last result has been handed to the output register. Reset empties the queue.
module ready_queue_min_quantum_select (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [2:0]                        func,
	input  logic [rqms_pkg::ID_BITS-1:0]      thread_id,
	input  logic                              ready_flag,
	input  logic [rqms_pkg::QUANTUM_BITS-1:0] quantum_count,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              front_valid,
	output logic [rqms_pkg::ID_BITS-1:0]      front_id,
	output logic                              front_ready,
	output logic [rqms_pkg::QUANTUM_BITS-1:0] front_quantum,
	output logic [rqms_pkg::CNT_W-1:0]        occupancy,
	output logic [1:0]                        status
);

	import rqms_pkg::*;

	// The queue is kept in logical order in one entry memory: the head lives at
	// address zero and the tail just below the entry count. Every operation is
	// carried out by the sequencer as a series of read, modify and write steps.
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	entry_t            mem_wdata;
	logic              mem_re;
	logic [IDX_W-1:0]  mem_raddr;
	entry_t            mem_rdata;
	logic              res_valid;
	logic              res_take;
	result_t           res;
	logic              out_valid_q;
	result_t           out_q;

	rqms_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	rqms_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.func          (func),
		.thread_id     (thread_id),
		.ready_flag    (ready_flag),
		.quantum_count (quantum_count),
		.mem_we        (mem_we),
		.mem_waddr     (mem_waddr),
		.mem_wdata     (mem_wdata),
		.mem_re        (mem_re),
		.mem_raddr     (mem_raddr),
		.mem_rdata     (mem_rdata),
		.res_valid     (res_valid),
		.res_take      (res_take),
		.res           (res)
	);

	// The output register decouples the two sides: the sequencer goes back to
	// idle and takes the next transaction while a finished result waits here.
	// A new result is only loaded once the held one has been taken.
	assign res_take = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign front_valid   = out_q.front_valid;
	assign front_id      = out_q.front_id;
	assign front_ready   = out_q.front_ready;
	assign front_quantum = out_q.front_quantum;
	assign occupancy     = out_q.occupancy;
	assign status        = out_q.status;

endmodule

// ===== rtl/rqms_ram.sv =====
module rqms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/rqms_seq.sv =====
`include "ready_queue_min_quantum_select_assert.svh"

module rqms_seq (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [2:0]                       func,
	input  logic [rqms_pkg::ID_BITS-1:0]     thread_id,
	input  logic                             ready_flag,
	input  logic [rqms_pkg::QUANTUM_BITS-1:0] quantum_count,
	output logic                             mem_we,
	output logic [rqms_pkg::IDX_W-1:0]       mem_waddr,
	output rqms_pkg::entry_t                 mem_wdata,
	output logic                             mem_re,
	output logic [rqms_pkg::IDX_W-1:0]       mem_raddr,
	input  rqms_pkg::entry_t                 mem_rdata,
	output logic                             res_valid,
	input  logic                             res_take,
	output rqms_pkg::result_t                res
);

	import rqms_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_SCAN_RD  = 7'b0000010,
		S_SCAN_EV  = 7'b0000100,
		S_MOVE_RD  = 7'b0001000,
		S_MOVE_WR  = 7'b0010000,
		S_FRONT_RD = 7'b0100000,
		S_DONE     = 7'b1000000
	} state_t;

	state_t                  state_q, state_d;
	logic [CNT_W-1:0]        count_q, count_d;
	logic [CNT_W-1:0]        idx_q, idx_d;
	logic [CNT_W-1:0]        pos_q, pos_d;
	status_t                 status_q, status_d;
	logic [2:0]              func_q;
	logic [ID_BITS-1:0]      id_q;
	logic                    rdy_q;
	logic [QUANTUM_BITS-1:0] qnt_q;
	entry_t                  best_q, best_d;

	logic             accept;
	logic [CNT_W-1:0] idx_inc;
	logic [CNT_W-1:0] idx_dec;
	logic             last;
	logic             hit;
	logic             take;
	logic             select_op;
	logic             res_load;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign idx_inc   = CNT_W'(idx_q + 1'b1);
	assign idx_dec   = CNT_W'(idx_q - 1'b1);
	assign last      = (idx_inc == count_q);
	assign hit       = (mem_rdata.id == id_q);
	assign select_op = (func_q == FN_SELECT);
	// The first entry seeds the search; later ones win only if ready and the best is not ready or strictly higher.
	assign take = (idx_q == '0) ||
		(mem_rdata.rdy && (!best_q.rdy || (mem_rdata.qnt < best_q.qnt)));

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		pos_d     = pos_q;
		status_d  = status_q;
		best_d    = best_q;
		mem_we    = 1'b0;
		mem_waddr = idx_q[IDX_W-1:0];
		mem_wdata = mem_rdata;
		mem_re    = 1'b0;
		mem_raddr = idx_q[IDX_W-1:0];

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					status_d = ST_OK;
					idx_d    = '0;
					pos_d    = '0;
					state_d  = S_FRONT_RD;
					case (func_t'(func))
						FN_PUSH: begin
							if (count_q == CNT_W'(QUEUE_DEPTH)) begin
								status_d = ST_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = count_q[IDX_W-1:0];
								mem_wdata = '{id: thread_id, rdy: ready_flag, qnt: quantum_count};
								count_d   = CNT_W'(count_q + 1'b1);
							end
						end
						FN_POP: begin
							if (count_q == '0) begin
								status_d = ST_EMPTY;
							end else begin
								state_d = S_MOVE_RD;
							end
						end
						FN_REMOVE, FN_SELECT, FN_UPDATE: begin
							if (count_q == '0) begin
								status_d = ST_EMPTY;
							end else begin
								state_d = S_SCAN_RD;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_SCAN_RD: begin
				mem_re  = 1'b1;
				state_d = S_SCAN_EV;
			end
			S_SCAN_EV: begin
				if (select_op) begin
					if (take) begin
						best_d = mem_rdata;
						pos_d  = idx_q;
					end
					if (last) begin
						idx_d   = take ? idx_q : pos_q;
						state_d = ((take ? idx_q : pos_q) == '0) ? S_FRONT_RD : S_MOVE_RD;
					end else begin
						idx_d   = idx_inc;
						state_d = S_SCAN_RD;
					end
				end else if (hit) begin
					if (func_q == FN_UPDATE) begin
						mem_we    = 1'b1;
						mem_wdata = '{id: mem_rdata.id, rdy: rdy_q, qnt: qnt_q};
						state_d   = S_FRONT_RD;
					end else begin
						state_d = S_MOVE_RD;
					end
				end else if (last) begin
					status_d = ST_MISSING;
					state_d  = S_FRONT_RD;
				end else begin
					idx_d   = idx_inc;
					state_d = S_SCAN_RD;
				end
			end
			S_MOVE_RD: begin
				if (select_op) begin
					// Shift toward the back, then drop the chosen entry at the head.
					if (idx_q == '0) begin
						mem_we    = 1'b1;
						mem_waddr = '0;
						mem_wdata = best_q;
						state_d   = S_FRONT_RD;
					end else begin
						mem_re    = 1'b1;
						mem_raddr = idx_dec[IDX_W-1:0];
						state_d   = S_MOVE_WR;
					end
				end else begin
					// Close the gap by moving each later entry one place forward.
					if (idx_inc >= count_q) begin
						count_d = CNT_W'(count_q - 1'b1);
						state_d = S_FRONT_RD;
					end else begin
						mem_re    = 1'b1;
						mem_raddr = idx_inc[IDX_W-1:0];
						state_d   = S_MOVE_WR;
					end
				end
			end
			S_MOVE_WR: begin
				mem_we  = 1'b1;
				idx_d   = select_op ? idx_dec : idx_inc;
				state_d = S_MOVE_RD;
			end
			S_FRONT_RD: begin
				mem_re    = 1'b1;
				mem_raddr = '0;
				state_d   = S_DONE;
			end
			S_DONE: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			idx_q    <= '0;
			pos_q    <= '0;
			status_q <= ST_OK;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			idx_q    <= idx_d;
			pos_q    <= pos_d;
			status_q <= status_d;
		end
	end

	always_ff @(posedge clk) begin
		best_q <= best_d;
		if (accept) begin
			func_q <= func;
			id_q   <= thread_id;
			rdy_q  <= ready_flag;
			qnt_q  <= quantum_count;
		end
	end

	assign res_valid = (state_q == S_DONE);
	assign res_load  = res_valid && res_take;

	always_comb begin
		res.front_valid   = (count_q != '0);
		res.front_id      = res.front_valid ? mem_rdata.id : '0;
		res.front_ready   = res.front_valid ? mem_rdata.rdy : 1'b0;
		res.front_quantum = res.front_valid ? mem_rdata.qnt : '0;
		res.occupancy     = count_q;
		res.status        = status_q;
	end

	`RQMS_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(QUEUE_DEPTH),
		"entry count exceeds queue depth")
	`RQMS_ASSERT_NOW(a_full_at_depth, res_load && (res.status == ST_FULL),
		res.occupancy == CNT_W'(QUEUE_DEPTH), "full status with free room")
	`RQMS_ASSERT_NOW(a_empty_no_front, res_load && (res.status == ST_EMPTY),
		!res.front_valid, "empty status with a head entry")
	`RQMS_ASSERT_NEXT(a_done_to_idle, res_load, state_q == S_IDLE,
		"sequencer did not return to idle after handing off a result")

endmodule

// ===== verif/run_queue_check.sv =====
`timescale 1ns / 100ps

// Watches both channels of the run queue, keeps its own copy of the queue and
// compares every returned result with the front entry, occupancy and status it should report.
module run_queue_check (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic [2:0]                        func,
	input  logic [rqms_pkg::ID_BITS-1:0]      thread_id,
	input  logic                              ready_flag,
	input  logic [rqms_pkg::QUANTUM_BITS-1:0] quantum_count,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic                              front_valid,
	input  logic [rqms_pkg::ID_BITS-1:0]      front_id,
	input  logic                              front_ready,
	input  logic [rqms_pkg::QUANTUM_BITS-1:0] front_quantum,
	input  logic [rqms_pkg::CNT_W-1:0]        occupancy,
	input  logic [1:0]                        status,
	output int                                mismatches,
	output int                                outstanding
);

	import rqms_pkg::*;

	entry_t  run_q[$];
	result_t front_expected[$];
	result_t oldest;
	int      fail_count = 0;
	int      waiting = 0;

	assign mismatches  = fail_count;
	assign outstanding = waiting;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $time);
		fail_count++;
	endtask

	// Applies one operation to the local queue copy and returns the front report.
	function automatic result_t apply_sched_op(input logic [2:0] op,
			input logic [ID_BITS-1:0] id, input logic rdy,
			input logic [QUANTUM_BITS-1:0] qnt);
		result_t r;
		entry_t  e;
		status_t st;
		int      pos;
		int      i;
		st  = ST_OK;
		pos = -1;
		case (op)
			FN_PUSH: begin
				if (run_q.size() >= QUEUE_DEPTH) begin
					st = ST_FULL;
				end else begin
					e.id  = id;
					e.rdy = rdy;
					e.qnt = qnt;
					run_q.push_back(e);
				end
			end
			FN_POP: begin
				if (run_q.size() == 0)
					st = ST_EMPTY;
				else
					void'(run_q.pop_front());
			end
			FN_REMOVE, FN_UPDATE: begin
				if (run_q.size() == 0) begin
					st = ST_EMPTY;
				end else begin
					for (i = 0; i < run_q.size(); i++) begin
						if (pos < 0 && run_q[i].id == id)
							pos = i;
					end
					if (pos < 0) begin
						st = ST_MISSING;
					end else if (op == FN_REMOVE) begin
						run_q.delete(pos);
					end else begin
						run_q[pos].rdy = rdy;
						run_q[pos].qnt = qnt;
					end
				end
			end
			FN_SELECT: begin
				if (run_q.size() == 0) begin
					st = ST_EMPTY;
				end else begin
					// Earliest ready entry with the lowest quantum; the head stays
					// when nothing is ready.
					pos = 0;
					for (i = 1; i < run_q.size(); i++) begin
						if (run_q[i].rdy && (!run_q[pos].rdy || run_q[i].qnt < run_q[pos].qnt))
							pos = i;
					end
					e = run_q[pos];
					run_q.delete(pos);
					run_q.push_front(e);
				end
			end
			default: ;
		endcase
		if (run_q.size() > 0) begin
			r.front_valid   = 1'b1;
			r.front_id      = run_q[0].id;
			r.front_ready   = run_q[0].rdy;
			r.front_quantum = run_q[0].qnt;
		end else begin
			r.front_valid   = 1'b0;
			r.front_id      = '0;
			r.front_ready   = 1'b0;
			r.front_quantum = '0;
		end
		r.occupancy = CNT_W'(run_q.size());
		r.status    = st;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q.delete();
			front_expected.delete();
			waiting <= 0;
		end else begin
			// A result always belongs to an earlier transaction, so it is checked
			// before a transaction accepted at the same edge is predicted.
			if (out_valid && out_ready) begin
				if (front_expected.size() == 0) begin
					report_mismatch("result with nothing expected", 32'(status), 32'd0);
				end else begin
					oldest = front_expected.pop_front();
					if (front_valid !== oldest.front_valid)
						report_mismatch("front_valid", 32'(front_valid),
								32'(oldest.front_valid));
					if (front_id !== oldest.front_id)
						report_mismatch("front_id", 32'(front_id), 32'(oldest.front_id));
					if (front_ready !== oldest.front_ready)
						report_mismatch("front_ready", 32'(front_ready),
								32'(oldest.front_ready));
					if (front_quantum !== oldest.front_quantum)
						report_mismatch("front_quantum", 32'(front_quantum),
								32'(oldest.front_quantum));
					if (occupancy !== oldest.occupancy)
						report_mismatch("occupancy", 32'(occupancy),
								32'(oldest.occupancy));
					if (status !== oldest.status)
						report_mismatch("status", 32'(status), 32'(oldest.status));
				end
			end
			if (in_valid && in_ready)
				front_expected.push_back(apply_sched_op(func, thread_id, ready_flag,
						quantum_count));
			waiting <= front_expected.size();
		end
	end

endmodule

// ===== verif/tb_ready_queue_min_quantum_select.sv =====
`timescale 1ns / 100ps

// Stimulus and verdict for the run queue. The companion module run_queue_check
// follows every transaction on both channels and counts mismatches; this module
// only produces operations, paces both sides and decides the outcome.
module tb_ready_queue_min_quantum_select;
	import rqms_pkg::*;

	// Function codes the block does not implement; they must leave the queue alone.
	localparam logic [2:0] FN_SPARE_LO = 3'd5;
	localparam logic [2:0] FN_SPARE_HI = 3'd7;

	// An id that the directed fill never uses, so lookups of it miss.
	localparam logic [ID_BITS-1:0] ABSENT_ID = 8'd200;

	localparam int RANDOM_OPS   = 1920;
	localparam int BIAS_BLOCK   = 64;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 100;
	localparam int CYCLE_LIMIT  = 1_000_000;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [2:0]              func = FN_PUSH;
	logic [ID_BITS-1:0]      thread_id = '0;
	logic                    ready_flag = 1'b0;
	logic [QUANTUM_BITS-1:0] quantum_count = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic                    front_valid;
	logic [ID_BITS-1:0]      front_id;
	logic                    front_ready;
	logic [QUANTUM_BITS-1:0] front_quantum;
	logic [CNT_W-1:0]        occupancy;
	logic [1:0]              status;

	int mismatches;
	int outstanding;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int cycle_count = 0;
	bit hold_request = 1'b0;

	always #10 clk = ~clk;

	ready_queue_min_quantum_select dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.thread_id    (thread_id),
		.ready_flag   (ready_flag),
		.quantum_count(quantum_count),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.front_valid  (front_valid),
		.front_id     (front_id),
		.front_ready  (front_ready),
		.front_quantum(front_quantum),
		.occupancy    (occupancy),
		.status       (status)
	);

	run_queue_check u_front_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.thread_id    (thread_id),
		.ready_flag   (ready_flag),
		.quantum_count(quantum_count),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.front_valid  (front_valid),
		.front_id     (front_id),
		.front_ready  (front_ready),
		.front_quantum(front_quantum),
		.occupancy    (occupancy),
		.status       (status),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	// Watchdog. A correct run needs a small fraction of this even with the
	// heaviest idling and the long receiver hold.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Result side. Normally it backs off at random; on request it holds off for
	// a long stretch, counted here, so that the block stalls its input while the
	// sender keeps a transaction pending.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Presents one operation and returns at the edge where the transaction is
	// accepted. Valid is left high so a back-to-back operation does not toggle it.
	task automatic submit_op(input logic [2:0] op, input logic [ID_BITS-1:0] id,
			input logic rdy, input logic [QUANTUM_BITS-1:0] qnt);
		func          <= op;
		thread_id     <= id;
		ready_flag    <= rdy;
		quantum_count <= qnt;
		in_valid      <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Random idle cycles on the operation side before the next transaction.
	task automatic sender_gap();
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Stops offering operations until every predicted result has been returned.
	// The first edge lets the count pick up the transaction just accepted.
	task automatic wait_all_returned();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// One random operation. Ids come mostly from a small pool so that remove and
	// update find their target often, and quanta are often small so that select
	// meets ties. push_pct steers the queue towards full or towards empty.
	task automatic random_op(input int push_pct);
		logic [2:0]              op;
		logic [ID_BITS-1:0]      id;
		logic [QUANTUM_BITS-1:0] qnt;
		int                      pick;
		pick = $urandom_range(99);
		if ($urandom_range(99) < push_pct)
			op = FN_PUSH;
		else if (pick < 20)
			op = FN_POP;
		else if (pick < 45)
			op = FN_REMOVE;
		else if (pick < 70)
			op = FN_SELECT;
		else if (pick < 96)
			op = FN_UPDATE;
		else
			op = 3'($urandom_range(FN_SPARE_HI, FN_SPARE_LO));
		if ($urandom_range(3) != 0)
			id = 8'($urandom_range(11) * 21);
		else
			id = 8'($urandom_range(255));
		case ($urandom_range(9))
			0:       qnt = 16'hFFFF;
			1:       qnt = 16'h0000;
			2, 3, 4, 5: qnt = 16'($urandom_range(7));
			default: qnt = 16'($urandom_range(65535));
		endcase
		sender_gap();
		submit_op(op, id, 1'($urandom_range(1)), qnt);
	endtask

	initial begin
		int phase;
		int n;
		int push_pct;

		// Phase one idling applies from the start, directed part included.
		send_idle_pct = 15;
		recv_idle_pct = 60;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every operation but push on an empty queue, plus an unused code there.
		submit_op(FN_POP, 8'h00, 1'b0, 16'h0000);
		submit_op(FN_REMOVE, 8'hFF, 1'b1, 16'hFFFF);
		submit_op(FN_SELECT, 8'h00, 1'b0, 16'h0000);
		submit_op(FN_UPDATE, 8'hFF, 1'b1, 16'hFFFF);
		submit_op(FN_SPARE_HI, 8'hFF, 1'b1, 16'hFFFF);

		// A lone entry that is not ready: select must leave it at the head.
		submit_op(FN_PUSH, 8'h00, 1'b0, 16'hFFFF);
		submit_op(FN_SELECT, 8'h00, 1'b0, 16'h0000);

		// Fill to capacity. Id 255 appears twice so that remove and update have
		// to act on the earlier copy; every third entry is ready with the same
		// quantum, so select has to break a tie in favor of the earliest one.
		submit_op(FN_PUSH, 8'hFF, 1'b0, 16'h0000);
		for (n = 0; n < QUEUE_DEPTH - 2; n++) begin
			submit_op(FN_PUSH, (n == 5) ? 8'hFF : 8'(20 + n * 7), (n % 3 == 1),
					(n % 3 == 1) ? 16'h0010 : 16'($urandom_range(16'hFFFF, 16'h0011)));
		end
		// A push to the full queue is dropped.
		submit_op(FN_PUSH, 8'h77, 1'b1, 16'h0000);

		// Head not ready: the earliest ready entry with the lowest quantum moves up.
		submit_op(FN_SELECT, 8'h00, 1'b0, 16'h0000);
		submit_op(FN_UPDATE, 8'hFF, 1'b1, 16'hFFFF);
		submit_op(FN_REMOVE, 8'hFF, 1'b0, 16'h0000);
		submit_op(FN_REMOVE, ABSENT_ID, 1'b0, 16'h0000);
		submit_op(FN_UPDATE, ABSENT_ID, 1'b1, 16'h0001);
		submit_op(FN_SPARE_LO, 8'h00, 1'b0, 16'h0000);
		wait_all_returned();

		// Three random phases with different pacing, each ending with a full
		// drain. Within a phase the push bias changes every block so the queue
		// swings between empty and full.
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 15;
					recv_idle_pct = 60;
				end
				1: begin
					send_idle_pct = 60;
					recv_idle_pct = 15;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			push_pct = 40;
			for (n = 0; n < RANDOM_OPS / 3; n++) begin
				if (n % BIAS_BLOCK == 0) begin
					case ($urandom_range(2))
						0:       push_pct = 75;
						1:       push_pct = 40;
						default: push_pct = 15;
					endcase
				end
				// Long result-side hold while operations keep coming.
				if (phase == 0 && n == 100)
					hold_request = 1'b1;
				random_op(push_pct);
			end
			wait_all_returned();
		end

		// Give a stray late result time to show up before the verdict.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
